[src/gae_pkg.sv]
// ----------------------------------------------------------------------------
// GEMV accumulate engine package
// Shared widths, codes, queue item and configuration types, and small helpers.
// ----------------------------------------------------------------------------
package gae_pkg;

    localparam int MAX_LEN     = 64;
    localparam int IDX_W       = $clog2(MAX_LEN);
    localparam int SIZE_W      = IDX_W + 1;
    localparam int DATA_W      = 32;
    localparam int ACC_W       = 64;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;
    localparam int CFG_IDX_W   = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA      = 3'd4;

    localparam logic [DATA_W-1:0] ALPHA_RESET = 32'h0001_0000;

    // Input operation codes.
    typedef enum logic [1:0] {
        OP_LOAD_X = 2'd0,
        OP_LOAD_Y = 2'd1,
        OP_MATRIX = 2'd2,
        OP_UNUSED = 2'd3
    } t_op;

    // What the back end has to do with a queued item.
    typedef enum logic [1:0] {
        K_LOAD_X = 2'd0,
        K_LOAD_Y = 2'd1,
        K_MAC    = 2'd2,
        K_FLUSH  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [IDX_W-1:0]   acc_idx;
        logic [IDX_W-1:0]   src_idx;
        logic [DATA_W-1:0]  value;
        logic               final_req;
    } t_item;

    typedef struct packed {
        logic               transpose;
        logic [SIZE_W-1:0]  out_count;
        logic [DATA_W-1:0]  alpha;
        logic [DATA_W-1:0]  beta;
    } t_cfg;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_MUL,
        BS_ACC,
        BS_RD,
        BS_MAG,
        BS_MHI,
        BS_MLO,
        BS_MY,
        BS_SIGN,
        BS_OUT
    } t_bstate;

    // Magnitude of a two's complement word; the most negative value maps to 2^31.
    function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (DATA_W'(0) - v) : v;
    endfunction

    // A size register of zero acts as one, anything above MAX_LEN as MAX_LEN.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > SIZE_W'(MAX_LEN)) begin
            r = SIZE_W'(MAX_LEN);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[src/gae_front.sv]
// ----------------------------------------------------------------------------
// GEMV accumulate engine front end
// Holds the configuration registers and classifies accepted items for the queue.
// ----------------------------------------------------------------------------
module gae_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gae_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gae_pkg::DATA_W-1:0]      i_cfg_data,
    input  logic                            i_accept,
    input  logic [1:0]                      i_op,
    input  logic [gae_pkg::IDX_W-1:0]       i_position,
    input  logic [gae_pkg::IDX_W-1:0]       i_row,
    input  logic [gae_pkg::IDX_W-1:0]       i_col,
    input  logic [gae_pkg::DATA_W-1:0]      i_value,
    input  logic                            i_final_req,
    output logic                            o_push,
    output gae_pkg::t_item                  o_item,
    output gae_pkg::t_cfg                   o_cfg
);

    logic                           r_transpose;
    logic [gae_pkg::SIZE_W-1:0]     r_rows;
    logic [gae_pkg::SIZE_W-1:0]     r_cols;
    logic [gae_pkg::DATA_W-1:0]     r_alpha;
    logic [gae_pkg::DATA_W-1:0]     r_beta;

    logic [gae_pkg::SIZE_W-1:0]     c_rows;
    logic [gae_pkg::SIZE_W-1:0]     c_cols;
    logic                           c_in_range;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transpose <= 1'b0;
            r_rows      <= gae_pkg::SIZE_W'(1);
            r_cols      <= gae_pkg::SIZE_W'(1);
            r_alpha     <= gae_pkg::ALPHA_RESET;
            r_beta      <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                gae_pkg::CFG_TRANSPOSE: r_transpose <= i_cfg_data[0];
                gae_pkg::CFG_ROWS:      r_rows      <= i_cfg_data[gae_pkg::SIZE_W-1:0];
                gae_pkg::CFG_COLS:      r_cols      <= i_cfg_data[gae_pkg::SIZE_W-1:0];
                gae_pkg::CFG_ALPHA:     r_alpha     <= i_cfg_data;
                gae_pkg::CFG_BETA:      r_beta      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign c_rows     = gae_pkg::eff_size(r_rows);
    assign c_cols     = gae_pkg::eff_size(r_cols);
    assign c_in_range = ({1'b0, i_row} < c_rows) && ({1'b0, i_col} < c_cols);

    always_comb begin
        o_cfg.transpose = r_transpose;
        o_cfg.out_count = r_transpose ? c_cols : c_rows;
        o_cfg.alpha     = r_alpha;
        o_cfg.beta      = r_beta;
    end

    // Matrix elements outside the matrix only matter when they end the pass.
    always_comb begin
        o_push           = 1'b0;
        o_item.kind      = gae_pkg::K_MAC;
        o_item.acc_idx   = r_transpose ? i_col : i_row;
        o_item.src_idx   = r_transpose ? i_row : i_col;
        o_item.value     = i_value;
        o_item.final_req = i_final_req;
        unique case (gae_pkg::t_op'(i_op))
            gae_pkg::OP_LOAD_X: begin
                o_push         = i_accept;
                o_item.kind    = gae_pkg::K_LOAD_X;
                o_item.src_idx = i_position;
            end
            gae_pkg::OP_LOAD_Y: begin
                o_push         = i_accept;
                o_item.kind    = gae_pkg::K_LOAD_Y;
                o_item.src_idx = i_position;
            end
            gae_pkg::OP_MATRIX: begin
                if (c_in_range) begin
                    o_push      = i_accept;
                    o_item.kind = gae_pkg::K_MAC;
                end else begin
                    o_push      = i_accept && i_final_req;
                    o_item.kind = gae_pkg::K_FLUSH;
                end
            end
            gae_pkg::OP_UNUSED: begin
                o_push = 1'b0;
            end
        endcase
    end

endmodule

[src/gae_queue.sv]
// ----------------------------------------------------------------------------
// GEMV accumulate engine item queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module gae_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gae_pkg::t_item  i_item,
    input  logic            i_pop,
    output gae_pkg::t_item  o_head,
    output logic            o_empty,
    output logic            o_full
);

    gae_pkg::t_item                 r_mem [gae_pkg::QUEUE_DEPTH];
    logic [gae_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [gae_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [gae_pkg::QCNT_W-1:0]     r_count;

    function automatic logic [gae_pkg::QPTR_W-1:0] next_ptr(
        input logic [gae_pkg::QPTR_W-1:0] p
    );
        return (p == gae_pkg::QPTR_W'(gae_pkg::QUEUE_DEPTH - 1)) ?
               '0 : p + gae_pkg::QPTR_W'(1);
    endfunction

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == gae_pkg::QCNT_W'(gae_pkg::QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + gae_pkg::QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - gae_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

[src/gae_back.sv]
// ----------------------------------------------------------------------------
// GEMV accumulate engine back end
// Sequencer with the vector, old output and accumulator memories, one shared
// 32x32 multiplier, and the scaling and saturation of the output run.
// ----------------------------------------------------------------------------
module gae_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gae_pkg::t_cfg                   i_cfg,
    input  logic                            i_empty,
    input  gae_pkg::t_item                  i_head,
    output logic                            o_pop,
    output logic                            o_valid,
    output logic [gae_pkg::IDX_W-1:0]       o_out_index,
    output logic [gae_pkg::DATA_W-1:0]      o_out_value,
    output logic                            o_saturated,
    output logic                            o_out_last
);

    localparam int MAG_W = gae_pkg::PROD_W - 16;     // Q16.16 product magnitude
    localparam int M_W   = MAG_W + 1;                // clamped alpha term magnitude
    localparam int T_W   = M_W + 1;                  // signed term
    localparam int S_W   = T_W + 1;                  // signed sum

    gae_pkg::t_bstate r_state;
    gae_pkg::t_bstate n_state;

    // Memories
    logic [gae_pkg::DATA_W-1:0]     r_x_mem   [gae_pkg::MAX_LEN];
    logic [gae_pkg::DATA_W-1:0]     r_y_mem   [gae_pkg::MAX_LEN];
    logic [gae_pkg::ACC_W-1:0]      r_acc_mem [gae_pkg::MAX_LEN];
    logic [gae_pkg::MAX_LEN-1:0]    r_acc_vld;

    logic [gae_pkg::DATA_W-1:0]     r_x_rd;
    logic [gae_pkg::DATA_W-1:0]     r_y_rd;
    logic [gae_pkg::ACC_W-1:0]      r_acc_rd;
    logic                           r_acc_rd_vld;

    // Datapath registers
    gae_pkg::t_item                 r_item;
    logic [gae_pkg::IDX_W-1:0]      r_idx;
    logic [gae_pkg::PROD_W-1:0]     r_prod;
    logic [gae_pkg::ACC_W-1:0]      r_am;
    logic                           r_neg;
    logic                           r_hi_big;
    logic [gae_pkg::DATA_W-1:0]     r_hi_lo;
    logic [M_W-1:0]                 r_m;
    logic [T_W-1:0]                 r_t1;
    logic [T_W-1:0]                 r_t2;
    logic                           r_valid;
    logic [gae_pkg::IDX_W-1:0]      r_out_index;
    logic [gae_pkg::DATA_W-1:0]     r_out_value;
    logic                           r_saturated;
    logic                           r_out_last;

    // Control
    logic                           c_pop;
    logic                           c_x_wr;
    logic                           c_y_wr;
    logic                           c_mac_rd;
    logic                           c_run_rd;
    logic                           c_acc_wr;
    logic                           c_emit;
    logic                           c_last;
    logic                           c_clear;
    logic                           c_run_start;
    logic                           c_acc_rd_en;
    logic [gae_pkg::IDX_W-1:0]      c_acc_rd_addr;

    // Arithmetic
    logic [gae_pkg::DATA_W-1:0]     c_mul_a;
    logic [gae_pkg::DATA_W-1:0]     c_mul_b;
    logic [gae_pkg::PROD_W-1:0]     c_mul_p;
    logic [gae_pkg::ACC_W-1:0]      c_acc_base;
    logic [gae_pkg::ACC_W-1:0]      c_acc_term;
    logic [gae_pkg::ACC_W-1:0]      c_acc_sum;
    logic                           c_mac_neg;
    logic [gae_pkg::ACC_W-1:0]      c_acc_run;
    logic [M_W-1:0]                 c_m_sum;
    logic [M_W-1:0]                 c_m;
    logic [T_W-1:0]                 c_beta_term;
    logic                           c_beta_neg;
    logic [S_W-1:0]                 c_total;
    logic                           c_over;

    assign c_last = ({1'b0, r_idx} + gae_pkg::SIZE_W'(1)) == i_cfg.out_count;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gae_pkg::BS_IDLE: begin
                if (!i_empty) begin
                    unique case (i_head.kind)
                        gae_pkg::K_LOAD_X: n_state = gae_pkg::BS_IDLE;
                        gae_pkg::K_LOAD_Y: n_state = gae_pkg::BS_IDLE;
                        gae_pkg::K_MAC:    n_state = gae_pkg::BS_MUL;
                        gae_pkg::K_FLUSH:  n_state = gae_pkg::BS_RD;
                    endcase
                end
            end
            gae_pkg::BS_MUL:  n_state = gae_pkg::BS_ACC;
            gae_pkg::BS_ACC:  n_state = r_item.final_req ? gae_pkg::BS_RD : gae_pkg::BS_IDLE;
            gae_pkg::BS_RD:   n_state = gae_pkg::BS_MAG;
            gae_pkg::BS_MAG:  n_state = gae_pkg::BS_MHI;
            gae_pkg::BS_MHI:  n_state = gae_pkg::BS_MLO;
            gae_pkg::BS_MLO:  n_state = gae_pkg::BS_MY;
            gae_pkg::BS_MY:   n_state = gae_pkg::BS_SIGN;
            gae_pkg::BS_SIGN: n_state = gae_pkg::BS_OUT;
            gae_pkg::BS_OUT:  n_state = c_last ? gae_pkg::BS_IDLE : gae_pkg::BS_RD;
            default:          n_state = gae_pkg::BS_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        c_pop       = (r_state == gae_pkg::BS_IDLE) && !i_empty;
        c_x_wr      = c_pop && (i_head.kind == gae_pkg::K_LOAD_X);
        c_y_wr      = c_pop && (i_head.kind == gae_pkg::K_LOAD_Y);
        c_mac_rd    = c_pop && (i_head.kind == gae_pkg::K_MAC);
        c_acc_wr    = (r_state == gae_pkg::BS_ACC);
        c_run_rd    = (r_state == gae_pkg::BS_RD);
        c_emit      = (r_state == gae_pkg::BS_OUT);
        c_clear     = c_emit && c_last;
        c_run_start = (c_pop && (i_head.kind == gae_pkg::K_FLUSH)) ||
                      (c_acc_wr && r_item.final_req);
        c_acc_rd_en   = c_mac_rd || c_run_rd;
        c_acc_rd_addr = c_mac_rd ? i_head.acc_idx : r_idx;
    end

    // Shared multiplier operands
    always_comb begin
        c_mul_a = '0;
        c_mul_b = '0;
        unique case (r_state)
            gae_pkg::BS_MUL: begin
                c_mul_a = gae_pkg::mag32(r_item.value);
                c_mul_b = gae_pkg::mag32(r_x_rd);
            end
            gae_pkg::BS_MHI: begin
                c_mul_a = r_am[gae_pkg::ACC_W-1:gae_pkg::DATA_W];
                c_mul_b = gae_pkg::mag32(i_cfg.alpha);
            end
            gae_pkg::BS_MLO: begin
                c_mul_a = r_am[gae_pkg::DATA_W-1:0];
                c_mul_b = gae_pkg::mag32(i_cfg.alpha);
            end
            gae_pkg::BS_MY: begin
                c_mul_a = gae_pkg::mag32(i_cfg.beta);
                c_mul_b = gae_pkg::mag32(r_y_rd);
            end
            default: begin
            end
        endcase
    end

    assign c_mul_p = c_mul_a * c_mul_b;

    // Accumulate step: add or subtract the truncated product magnitude.
    assign c_mac_neg  = r_item.value[gae_pkg::DATA_W-1] ^ r_x_rd[gae_pkg::DATA_W-1];
    assign c_acc_base = r_acc_rd_vld ? r_acc_rd : '0;
    assign c_acc_term = gae_pkg::ACC_W'(r_prod[gae_pkg::PROD_W-1:16]);
    assign c_acc_sum  = c_mac_neg ? (c_acc_base - c_acc_term) : (c_acc_base + c_acc_term);

    // Output run arithmetic
    assign c_acc_run = r_acc_rd_vld ? r_acc_rd : '0;
    assign c_m_sum   = M_W'({r_hi_lo, 16'd0}) + M_W'(r_prod[gae_pkg::PROD_W-1:16]);
    assign c_m       = (r_hi_big || (c_m_sum > (M_W'(1) << 48))) ? (M_W'(1) << 48) : c_m_sum;

    assign c_beta_neg  = i_cfg.beta[gae_pkg::DATA_W-1] ^ r_y_rd[gae_pkg::DATA_W-1];
    assign c_beta_term = c_beta_neg ? (T_W'(0) - T_W'(r_prod[gae_pkg::PROD_W-1:16])) :
                                      T_W'(r_prod[gae_pkg::PROD_W-1:16]);

    assign c_total = {r_t1[T_W-1], r_t1} + {r_t2[T_W-1], r_t2};
    assign c_over  = !((&c_total[S_W-1:gae_pkg::DATA_W-1]) ||
                       (~|c_total[S_W-1:gae_pkg::DATA_W-1]));

    // Memories
    always_ff @(posedge i_clk) begin
        if (c_x_wr) begin
            r_x_mem[i_head.src_idx] <= i_head.value;
        end
        if (c_mac_rd) begin
            r_x_rd <= r_x_mem[i_head.src_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_y_wr) begin
            r_y_mem[i_head.src_idx] <= i_head.value;
        end
        if (c_run_rd) begin
            r_y_rd <= r_y_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_acc_wr) begin
            r_acc_mem[r_item.acc_idx] <= c_acc_sum;
        end
        if (c_acc_rd_en) begin
            r_acc_rd     <= r_acc_mem[c_acc_rd_addr];
            r_acc_rd_vld <= r_acc_vld[c_acc_rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gae_pkg::BS_IDLE;
            r_acc_vld <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= c_emit;
            if (c_clear) begin
                r_acc_vld <= '0;
            end else if (c_acc_wr) begin
                r_acc_vld[r_item.acc_idx] <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= c_mul_p;
        if (c_mac_rd) begin
            r_item <= i_head;
        end
        if (c_run_start) begin
            r_idx <= '0;
        end else if (c_emit && !c_last) begin
            r_idx <= r_idx + gae_pkg::IDX_W'(1);
        end
        if (r_state == gae_pkg::BS_MAG) begin
            r_neg <= c_acc_run[gae_pkg::ACC_W-1] ^ i_cfg.alpha[gae_pkg::DATA_W-1];
            r_am  <= c_acc_run[gae_pkg::ACC_W-1] ? (gae_pkg::ACC_W'(0) - c_acc_run) : c_acc_run;
        end
        if (r_state == gae_pkg::BS_MLO) begin
            r_hi_big <= (r_prod[gae_pkg::PROD_W-1:gae_pkg::DATA_W] != '0);
            r_hi_lo  <= r_prod[gae_pkg::DATA_W-1:0];
        end
        if (r_state == gae_pkg::BS_MY) begin
            r_m <= c_m;
        end
        if (r_state == gae_pkg::BS_SIGN) begin
            r_t1 <= r_neg ? (T_W'(0) - {1'b0, r_m}) : {1'b0, r_m};
            r_t2 <= (i_cfg.beta != '0) ? c_beta_term : '0;
        end
        if (c_emit) begin
            r_out_index <= r_idx;
            r_out_last  <= c_last;
            r_saturated <= c_over;
            if (c_over) begin
                r_out_value <= c_total[S_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                r_out_value <= c_total[gae_pkg::DATA_W-1:0];
            end
        end
    end

    assign o_pop       = c_pop;
    assign o_valid     = r_valid;
    assign o_out_index = r_out_index;
    assign o_out_value = r_out_value;
    assign o_saturated = r_saturated;
    assign o_out_last  = r_out_last;

endmodule

[src/gemv_accumulate_engine_top.sv]
// ----------------------------------------------------------------------------
// GEMV accumulate engine
// Computes y = alpha * op(A) * x + beta * y in signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                       Beat contents
//  -------   -----------------------------   ------------------------------------
//  input     start high while busy low       op, position, row, col, value,
//                                            final_req
//  config    i_cfg_valid and o_cfg_ready     register index, write data
//  result    o_valid strobe, one cycle       out_index, out_value, saturated,
//                                            out_last
//
// A vector or old output load is done at the pop; a matrix element is read,
// multiplied and accumulated. The element that ends a pass then starts the
// output run, where the single shared 32x32 multiplier forms the high and low
// alpha partial products and the beta product in turn for each output element.
// Reset is synchronous and active low; accumulators come out of reset as zero
// through their valid bits, and no clearing pass is needed. A four-entry queue
// sits between the front end and the back end; busy rises only when that queue
// is full. Results cannot be held off by the receiver.
//
module gemv_accumulate_engine_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Item beats
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_op,
    input  logic [gae_pkg::IDX_W-1:0]       i_position,
    input  logic [gae_pkg::IDX_W-1:0]       i_row,
    input  logic [gae_pkg::IDX_W-1:0]       i_col,
    input  logic signed [gae_pkg::DATA_W-1:0] i_value,
    input  logic                            i_final_req,
    // Configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gae_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gae_pkg::DATA_W-1:0]      i_cfg_data,
    // Result beats
    output logic                            o_valid,
    output logic [gae_pkg::IDX_W-1:0]       o_out_index,
    output logic signed [gae_pkg::DATA_W-1:0] o_out_value,
    output logic                            o_saturated,
    output logic                            o_out_last
);

    logic               w_accept;
    logic               w_push;
    logic               w_pop;
    logic               w_empty;
    logic               w_full;
    gae_pkg::t_item     w_item;
    gae_pkg::t_item     w_head;
    gae_pkg::t_cfg      w_cfg;

    // An item is taken whenever the queue has room; the front end decides
    // whether it becomes a queue entry at all (unused codes and stray matrix
    // elements that do not end a pass are dropped there).
    assign busy     = w_full;
    assign w_accept = start && !busy;

    gae_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .i_op        (i_op),
        .i_position  (i_position),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .i_final_req (i_final_req),
        .o_push      (w_push),
        .o_item      (w_item),
        .o_cfg       (w_cfg)
    );

    gae_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    // The back end owns all arithmetic and storage and reads the registers directly.
    // The user must change configuration only while the engine is idle (unchecked).
    gae_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_empty     (w_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .o_out_index (o_out_index),
        .o_out_value (o_out_value),
        .o_saturated (o_saturated),
        .o_out_last  (o_out_last)
    );

endmodule

[src/gae_checker.sv]
// ----------------------------------------------------------------------------
// GEMV accumulate engine checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module gae_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         busy,
    input logic                         o_valid,
    input logic [gae_pkg::IDX_W-1:0]    o_out_index,
    input logic [gae_pkg::DATA_W-1:0]   o_out_value,
    input logic                         o_saturated,
    input logic                         o_out_last
);

    // Reset leaves no result pending and the queue empty.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !busy))
        else $error("result or busy seen right after reset");

    // Results are never on consecutive cycles.
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two result beats in a row");

    // Within a run the next element follows with the next index.
    a_run_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out_last) |-> ##7
        (o_valid && (o_out_index == $past(o_out_index, 7) + 6'd1)))
        else $error("output run out of order or out of step");

    // A saturated result is pinned at one of the two limits.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
        ((o_out_value == 32'h7FFF_FFFF) || (o_out_value == 32'h8000_0000)))
        else $error("saturated flag without a limit value");

endmodule

bind gemv_accumulate_engine_top gae_checker u_gae_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_out_index (o_out_index),
    .o_out_value (o_out_value),
    .o_saturated (o_saturated),
    .o_out_last  (o_out_last)
);

[sim/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GEMV accumulate engine testbench
// Streams vector loads, old output loads and matrix elements into the engine
// under several register settings, predicts every y element in Q16.16, and
// checks each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

    import gae_pkg::*;

    // Register index that no register answers to; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    localparam int          RANDOM_BEATS = 100;
    localparam int          TAIL_CYCLES  = 40;
    localparam int unsigned LIMIT_CYCLES = 1000000;

    localparam logic [63:0] MAG_CLAMP = 64'h0001_0000_0000_0000;
    localparam longint      Y_MAX     = 64'sd2147483647;
    localparam longint      Y_MIN     = -64'sd2147483648;

    // One item beat as the engine sees it.
    typedef struct packed {
        t_op                op;
        logic [IDX_W-1:0]   position;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [DATA_W-1:0]  value;
        logic               final_req;
    } gemv_beat_t;

    // One element of the new y vector.
    typedef struct packed {
        logic [IDX_W-1:0]   index;
        logic [DATA_W-1:0]  value;
        logic               sat;
        logic               last;
    } y_elem_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the block's inputs. Every input has a known value from
    // time zero.
    // ------------------------------------------------------------------------
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   start       = 1'b0;
    logic [1:0]             i_op        = '0;
    logic [IDX_W-1:0]       i_position  = '0;
    logic [IDX_W-1:0]       i_row       = '0;
    logic [IDX_W-1:0]       i_col       = '0;
    logic [DATA_W-1:0]      i_value     = '0;
    logic                   i_final_req = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [DATA_W-1:0]      i_cfg_data  = '0;

    logic                   busy;
    logic                   o_cfg_ready;
    logic                   o_valid;
    logic [IDX_W-1:0]       o_out_index;
    logic [DATA_W-1:0]      o_out_value;
    logic                   o_saturated;
    logic                   o_out_last;

    always #1 i_clk = ~i_clk;

    gemv_accumulate_engine_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_position  (i_position),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .i_final_req (i_final_req),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_out_index (o_out_index),
        .o_out_value (o_out_value),
        .o_saturated (o_saturated),
        .o_out_last  (o_out_last)
    );

    // ------------------------------------------------------------------------
    // Shared state of the bench.
    // ------------------------------------------------------------------------
    gemv_beat_t pending_beats[$];   // beats waiting for the driver
    y_elem_t    y_expected[$];      // predicted y elements, oldest first

    // Our own copy of the registers, updated on each accepted write beat.
    logic               cfg_transpose = 1'b0;
    logic [SIZE_W-1:0]  cfg_rows      = SIZE_W'(1);
    logic [SIZE_W-1:0]  cfg_cols      = SIZE_W'(1);
    logic [DATA_W-1:0]  cfg_alpha     = ALPHA_RESET;
    logic [DATA_W-1:0]  cfg_beta      = '0;

    // Predicted contents of the engine's stores.
    longint             acc_bank [MAX_LEN] = '{default: 0};
    logic [DATA_W-1:0]  x_store  [MAX_LEN] = '{default: '0};
    logic [DATA_W-1:0]  y_store  [MAX_LEN] = '{default: '0};

    // Which store entries the stimulus has written so far. The generator only
    // lets a read happen on entries marked here.
    bit                 x_loaded [MAX_LEN] = '{default: 1'b0};
    bit                 y_loaded [MAX_LEN] = '{default: 1'b0};

    bit                 no_gaps = 1'b0;
    int                 mismatches = 0;
    int                 beats_accepted = 0;
    int                 matrix_beats = 0;
    int                 output_passes = 0;
    int                 y_checked = 0;
    int                 y_clipped = 0;
    int                 settings_used = 0;
    int unsigned        cycle_count = 0;

    // ------------------------------------------------------------------------
    // Q16.16 arithmetic of the engine.
    // ------------------------------------------------------------------------

    // A size register of zero behaves as one, anything above MAX_LEN as MAX_LEN.
    function automatic int size_of(input logic [SIZE_W-1:0] v);
        if (v == '0)
            return 1;
        if (int'(v) > MAX_LEN)
            return MAX_LEN;
        return int'(v);
    endfunction

    // Exact 32x32 product shifted right by 16, truncated toward zero.
    function automatic longint fx_mul(input logic [DATA_W-1:0] a,
                                      input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] ma;
        logic [DATA_W-1:0] mb;
        logic [63:0]       m;
        ma = a[DATA_W-1] ? -a : a;
        mb = b[DATA_W-1] ? -b : b;
        m  = ({32'b0, ma} * {32'b0, mb}) >> 16;
        return (a[DATA_W-1] ^ b[DATA_W-1]) ? -longint'(m) : longint'(m);
    endfunction

    // alpha times a 64-bit accumulator. The magnitude is clamped to 2^48,
    // which is far outside the 32-bit result range, so clipping stays exact.
    function automatic longint scale_by_alpha(input logic [DATA_W-1:0] a,
                                              input longint acc);
        logic [63:0]       am;
        logic [63:0]       hi;
        logic [63:0]       lo;
        logic [63:0]       m;
        logic [DATA_W-1:0] sm;
        am = acc[63] ? (64'd0 - 64'(acc)) : 64'(acc);
        sm = a[DATA_W-1] ? -a : a;
        hi = (am >> 32) * {32'b0, sm};
        lo = ({32'b0, am[31:0]} * {32'b0, sm}) >> 16;
        if (hi >= 64'h0000_0001_0000_0000) begin
            m = MAG_CLAMP;
        end else begin
            m = (hi << 16) + lo;
            if (m > MAG_CLAMP)
                m = MAG_CLAMP;
        end
        return (acc[63] ^ a[DATA_W-1]) ? -longint'(m) : longint'(m);
    endfunction

    // Applies one accepted beat to the predicted state; a matrix beat that
    // closes a pass queues the whole new y vector.
    function automatic void absorb_beat(input gemv_beat_t b);
        int      rows_e;
        int      cols_e;
        int      count;
        int      acc_i;
        int      x_i;
        longint  total;
        y_elem_t e;
        rows_e = size_of(cfg_rows);
        cols_e = size_of(cfg_cols);
        case (b.op)
            OP_LOAD_X: x_store[b.position] = b.value;
            OP_LOAD_Y: y_store[b.position] = b.value;
            OP_MATRIX: begin
                // Elements outside the stored matrix add nothing, but a
                // final_req on one still closes the pass.
                if (int'(b.row) < rows_e && int'(b.col) < cols_e) begin
                    acc_i = cfg_transpose ? int'(b.col) : int'(b.row);
                    x_i   = cfg_transpose ? int'(b.row) : int'(b.col);
                    acc_bank[acc_i] += fx_mul(b.value, x_store[x_i]);
                end
                if (b.final_req) begin
                    count = cfg_transpose ? cols_e : rows_e;
                    for (int i = 0; i < count; i++) begin
                        total = scale_by_alpha(cfg_alpha, acc_bank[i]);
                        // A zero beta never touches the old output store.
                        if (cfg_beta != '0)
                            total += fx_mul(cfg_beta, y_store[i]);
                        e.sat = 1'b0;
                        if (total > Y_MAX) begin
                            total = Y_MAX;
                            e.sat = 1'b1;
                        end else if (total < Y_MIN) begin
                            total = Y_MIN;
                            e.sat = 1'b1;
                        end
                        e.index = IDX_W'(i);
                        e.value = total[DATA_W-1:0];
                        e.last  = (i == count - 1);
                        y_expected.push_back(e);
                    end
                    acc_bank = '{default: 0};
                    output_passes++;
                end
            end
            default: ;  // the spare op code does nothing
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic gemv_beat_t make_beat(input t_op op, input int pos,
                                             input int row, input int col,
                                             input logic [DATA_W-1:0] val,
                                             input bit fin);
        gemv_beat_t b;
        b.op        = op;
        b.position  = IDX_W'(pos);
        b.row       = IDX_W'(row);
        b.col       = IDX_W'(col);
        b.value     = val;
        b.final_req = fin;
        return b;
    endfunction

    // Element values: extremes, small numbers that keep sums in range, and
    // full-width noise.
    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 7))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            2: v = '0;
            3, 4: v = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // Scale factors for alpha and beta, centered on +-1.0 and the extremes.
    function automatic logic [DATA_W-1:0] pick_scale();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 7))
            0: v = ALPHA_RESET;
            1: v = 32'h8000_0000;
            2: v = 32'h7FFF_FFFF;
            3: v = 32'hFFFF_0000;
            4, 5: v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            6: v = $urandom();
            default: v = '0;
        endcase
        return v;
    endfunction

    // Matrix sizes are mostly small; zero, 64 and the out-of-range codes show
    // up now and then.
    function automatic logic [SIZE_W-1:0] pick_size();
        logic [SIZE_W-1:0] s;
        case ($urandom_range(0, 19))
            0: s = '0;
            1: s = SIZE_W'(MAX_LEN);
            2: s = SIZE_W'($urandom_range(MAX_LEN + 1, 127));
            3: s = SIZE_W'(1);
            default: s = SIZE_W'($urandom_range(2, 8));
        endcase
        return s;
    endfunction

    // Hands a beat to the driver and remembers which store entries it fills.
    task automatic queue_beat(input gemv_beat_t b);
        if (b.op == OP_LOAD_X)
            x_loaded[b.position] = 1'b1;
        if (b.op == OP_LOAD_Y)
            y_loaded[b.position] = 1'b1;
        pending_beats.push_back(b);
    endtask

    // One register write beat; called at a rising edge. The valid drops after each
    // write so that it never sees two assignments in one step.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [DATA_W-1:0] data);
        while (!no_gaps && $urandom_range(0, 99) < 23)
            @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_TRANSPOSE: cfg_transpose = data[0];
            CFG_ROWS:      cfg_rows      = data[SIZE_W-1:0];
            CFG_COLS:      cfg_cols      = data[SIZE_W-1:0];
            CFG_ALPHA:     cfg_alpha     = data;
            CFG_BETA:      cfg_beta      = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until every beat went in and every y element came out, then
    // gives beats that produce nothing time to leave the engine's queue.
    // The check runs on the falling edge, where everything has settled.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_beats.size() != 0 || start || y_expected.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string what);
        if (mismatches < 10)
            $display("%0t: %s", $realtime, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Driver. A beat goes in at the edge where start is high and busy is low.
    // A presented beat is held until it is taken; otherwise the next one is
    // put up, or the line idles about 23 times in a hundred unless no_gaps is set.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : beat_driver
        gemv_beat_t nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                nxt = pending_beats.pop_front();
                absorb_beat(nxt);
                beats_accepted++;
                if (nxt.op == OP_MATRIX)
                    matrix_beats++;
            end
            if (!(start && busy)) begin
                if (pending_beats.size() != 0 &&
                    (no_gaps || $urandom_range(0, 99) >= 23)) begin
                    nxt = pending_beats[0];
                    i_op        <= nxt.op;
                    i_position  <= nxt.position;
                    i_row       <= nxt.row;
                    i_col       <= nxt.col;
                    i_value     <= nxt.value;
                    i_final_req <= nxt.final_req;
                    start       <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Results cannot be held off, so every strobe is one y element
    // that must match the oldest prediction field by field.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : y_monitor
        y_elem_t want;
        if (i_rst_n && o_valid) begin
            if (y_expected.size() == 0) begin
                note_mismatch($sformatf("y element with none predicted: index %0d value %h",
                                        o_out_index, o_out_value));
            end else begin
                want = y_expected.pop_front();
                y_checked++;
                if (o_saturated === 1'b1)
                    y_clipped++;
                if (o_out_index !== want.index || o_out_value !== want.value ||
                    o_saturated !== want.sat || o_out_last !== want.last) begin
                    note_mismatch($sformatf(
                        "y mismatch: want idx %0d val %h sat %b last %b, got %0d %h %b %b",
                        want.index, want.value, want.sat, want.last,
                        o_out_index, o_out_value, o_saturated, o_out_last));
                end
            end
        end
    end

    // Watchdog: the slowest legal run is far below this.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin : sequencer
        int          rows_e;
        int          cols_e;
        int          vec_len;
        int          out_len;
        int          n_elems;
        int          r;
        int          c;
        int          random_beats;
        int          pass_no;
        logic [DATA_W-1:0] beta_pick;

        random_beats = 0;
        pass_no      = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: 1x1 matrix, alpha 1.0, beta 0. Loads at both ends
        // of the stores, a final_req on loads that must do nothing, the spare
        // op code, and a pass closed by an element outside the matrix. The
        // single product is near 2^46 and must clip high.
        settings_used++;
        @(negedge i_clk);
        queue_beat(make_beat(OP_LOAD_X, 0, 0, 0, 32'h7FFF_FFFF, 1'b0));
        queue_beat(make_beat(OP_LOAD_X, 63, 63, 63, 32'h8000_0000, 1'b1));
        queue_beat(make_beat(OP_LOAD_Y, 63, 0, 0, 32'h8000_0000, 1'b1));
        queue_beat(make_beat(OP_UNUSED, 63, 63, 63, 32'hFFFF_FFFF, 1'b1));
        queue_beat(make_beat(OP_MATRIX, 0, 0, 0, 32'h7FFF_FFFF, 1'b0));
        queue_beat(make_beat(OP_MATRIX, 0, 63, 63, 32'h8000_0000, 1'b1));
        wait_drained();

        // Transposed, a row count of zero that acts as one, alpha and beta at
        // opposite extremes. Clips in both directions, and an element whose
        // row lies past the matrix.
        write_register(CFG_TRANSPOSE, 32'd1);
        write_register(CFG_ROWS, 32'd0);
        write_register(CFG_COLS, 32'd3);
        write_register(CFG_ALPHA, 32'h8000_0000);
        write_register(CFG_BETA, 32'h7FFF_FFFF);
        settings_used++;
        @(negedge i_clk);
        queue_beat(make_beat(OP_LOAD_Y, 0, 0, 0, 32'h8000_0000, 1'b0));
        queue_beat(make_beat(OP_LOAD_Y, 1, 0, 0, 32'h7FFF_FFFF, 1'b0));
        queue_beat(make_beat(OP_LOAD_Y, 2, 0, 0, 32'h0000_0000, 1'b0));
        queue_beat(make_beat(OP_MATRIX, 0, 0, 0, 32'h8000_0000, 1'b0));
        queue_beat(make_beat(OP_MATRIX, 0, 0, 2, 32'h0001_0000, 1'b0));
        queue_beat(make_beat(OP_MATRIX, 0, 1, 1, 32'h7FFF_FFFF, 1'b1));
        wait_drained();

        // A write to an index no register owns, a row count above MAX_LEN with
        // junk in the upper data bits, and beta back at zero: a 64-element
        // pass that must not read the mostly unwritten old output store.
        write_register(CFG_SPARE, 32'hFFFF_FFFF);
        write_register(CFG_TRANSPOSE, 32'hFFFF_FFFE);
        write_register(CFG_ROWS, 32'hABCD_EF64);
        write_register(CFG_COLS, 32'd1);
        write_register(CFG_ALPHA, ALPHA_RESET);
        write_register(CFG_BETA, 32'd0);
        settings_used++;
        @(negedge i_clk);
        queue_beat(make_beat(OP_MATRIX, 0, 5, 0, 32'hFFFF_0000, 1'b0));
        queue_beat(make_beat(OP_MATRIX, 0, 63, 0, 32'h0000_0001, 1'b1));
        wait_drained();

        // Random passes. Each one picks new settings, loads whatever part of
        // the stores it will read and has not been written yet, then streams a
        // run of elements closed by final_req, with stray beats mixed in.
        while (random_beats < RANDOM_BEATS) begin
            // A long stretch of passes with the sender never pausing.
            no_gaps = (pass_no >= 2 && pass_no < 5);

            if (pass_no == 0 || $urandom_range(0, 3) != 0)
                write_register(CFG_TRANSPOSE,
                               ($urandom() & 32'hFFFF_FFFE) | 32'($urandom_range(0, 1)));
            if (pass_no == 0 || $urandom_range(0, 3) != 0)
                write_register(CFG_ROWS, ($urandom_range(0, 3) == 0 ?
                               ($urandom() & 32'hFFFF_FF80) : 32'd0) | 32'(pick_size()));
            if (pass_no == 0 || $urandom_range(0, 3) != 0)
                write_register(CFG_COLS, ($urandom_range(0, 3) == 0 ?
                               ($urandom() & 32'hFFFF_FF80) : 32'd0) | 32'(pick_size()));
            if (pass_no == 0 || $urandom_range(0, 3) != 0)
                write_register(CFG_ALPHA, pick_scale());
            if (pass_no == 0 || $urandom_range(0, 3) != 0) begin
                beta_pick = ($urandom_range(0, 2) == 0) ? 32'd0 : pick_scale();
                write_register(CFG_BETA, beta_pick);
            end
            if ($urandom_range(0, 6) == 0)
                write_register(CFG_SPARE, $urandom());
            settings_used++;

            rows_e  = size_of(cfg_rows);
            cols_e  = size_of(cfg_cols);
            vec_len = cfg_transpose ? rows_e : cols_e;
            out_len = cfg_transpose ? cols_e : rows_e;

            @(negedge i_clk);
            for (int k = 0; k < vec_len; k++) begin
                if (!x_loaded[k]) begin
                    queue_beat(make_beat(OP_LOAD_X, k, $urandom_range(0, 63),
                               $urandom_range(0, 63), pick_value(),
                               1'($urandom_range(0, 1))));
                    random_beats++;
                end
            end
            if (cfg_beta != '0) begin
                for (int k = 0; k < out_len; k++) begin
                    if (!y_loaded[k]) begin
                        queue_beat(make_beat(OP_LOAD_Y, k, 0, 0, pick_value(), 1'b0));
                        random_beats++;
                    end
                end
            end
            repeat ($urandom_range(0, 2)) begin
                queue_beat(make_beat($urandom_range(0, 1) ? OP_LOAD_Y : OP_LOAD_X,
                           $urandom_range(0, 63), $urandom_range(0, 63),
                           $urandom_range(0, 63), pick_value(),
                           1'($urandom_range(0, 1))));
                random_beats++;
            end

            // Mostly short runs, sometimes a long one that piles up sums.
            n_elems = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 8);
            for (int k = 0; k < n_elems; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    if ($urandom_range(0, 1)) begin
                        queue_beat(make_beat(OP_UNUSED, $urandom_range(0, 63),
                                   $urandom_range(0, 63), $urandom_range(0, 63),
                                   $urandom(), 1'($urandom_range(0, 1))));
                    end else begin
                        queue_beat(make_beat($urandom_range(0, 1) ? OP_LOAD_Y : OP_LOAD_X,
                                   $urandom_range(0, 63), 0, 0, pick_value(),
                                   1'($urandom_range(0, 1))));
                        random_beats++;
                    end
                end
                r = $urandom_range(0, rows_e - 1);
                c = $urandom_range(0, cols_e - 1);
                // About one element in seven lies outside the stored matrix.
                if ($urandom_range(0, 6) == 0) begin
                    if (rows_e < MAX_LEN && (cols_e == MAX_LEN || $urandom_range(0, 1))) begin
                        r = $urandom_range(rows_e, 63);
                        c = $urandom_range(0, 63);
                    end else if (cols_e < MAX_LEN) begin
                        c = $urandom_range(cols_e, 63);
                        r = $urandom_range(0, 63);
                    end
                end
                queue_beat(make_beat(OP_MATRIX, $urandom_range(0, 63), r, c,
                                     pick_value(), k == n_elems - 1));
                random_beats++;
            end

            // A beat that produces nothing may trail the pass; the drain wait
            // covers it before the next register write.
            if ($urandom_range(0, 3) == 0)
                queue_beat(make_beat(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                           $urandom_range(0, 63), $urandom(), 1'($urandom_range(0, 1))));

            wait_drained();
            pass_no++;
        end

        $display("Covered %0d beats (%0d matrix elements) over %0d register settings.",
                 beats_accepted, matrix_beats, settings_used);
        $display("Checked %0d y elements from %0d output passes, %0d of them clipped.",
                 y_checked, output_passes, y_clipped);
        if (mismatches == 0 && y_expected.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
